@@ rtl/cdq_pkg.sv @@
// cdq_pkg: operation and status codes, field widths and word types for the
// circular deque. No dependencies; imported by every other file of the block.
package cdq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [OP_W-1:0]          op_t;
  typedef logic [STAT_W-1:0]        status_t;
  typedef logic [OCC_W-1:0]         occ_t;

  localparam op_t OP_PUSH_REAR  = 2'd0;
  localparam op_t OP_PUSH_FRONT = 2'd1;
  localparam op_t OP_POP_FRONT  = 2'd2;
  localparam op_t OP_POP_REAR   = 2'd3;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

endpackage

@@ rtl/cdq_if.sv @@
// cdq_if: valid/ready channel interfaces for deque requests and results.
// Depends on cdq_pkg for the payload types.
interface cdq_in_if;
  import cdq_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  word_t push_value;
  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;
  logic    valid;
  logic    ready;
  word_t   popped_value;
  status_t status;
  occ_t    occupancy;
  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface

@@ rtl/cdq_ram.sv @@
// cdq_ram: element store, one write port and one read port, registered read.
// Depends on cdq_pkg for the word width.
module cdq_ram #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cdq_pkg::word_t           wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output cdq_pkg::word_t           rdata
);
  import cdq_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cdq_ctrl.sv @@
// cdq_ctrl: front/rear pointers, element count, pop read sequencing and the
// result register. Depends on cdq_pkg and cdq_if; drives the cdq_ram ports.
module cdq_ctrl #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  cdq_in_if.sink                   in_ch,
  cdq_out_if.source                out_ch,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output cdq_pkg::word_t           mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  cdq_pkg::word_t           mem_rdata
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [AW-1:0]   rear_r, rear_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r;
  word_t           popped_r;
  status_t         status_r;
  occ_t            occ_r;

  logic            accept;
  logic            is_push;
  logic            empty;
  logic            full;
  logic            load_done;
  status_t         done_status;
  logic [AW-1:0]   next_rear, prev_rear, next_front, prev_front;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.operation == OP_PUSH_REAR) ||
                       (in_ch.operation == OP_PUSH_FRONT);
  assign empty       = (count_r == '0);
  assign full        = (count_r == CW'(DEPTH));

  assign next_rear  = (rear_r == AW'(DEPTH - 1)) ? '0 : rear_r + 1'b1;
  assign prev_rear  = (rear_r == '0) ? AW'(DEPTH - 1) : rear_r - 1'b1;
  assign next_front = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign prev_front = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.status       = status_r;
  assign out_ch.occupancy    = occ_r;

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = in_ch.push_value;
    mem_re      = 1'b0;
    mem_raddr   = front_r;
    load_done   = 1'b0;
    done_status = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_push) begin
            load_done = 1'b1;
            if (full) begin
              done_status = ST_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
              if (empty) begin
                front_nxt = '0;
                rear_nxt  = '0;
                mem_waddr = '0;
              end else if (in_ch.operation == OP_PUSH_REAR) begin
                rear_nxt  = next_rear;
                mem_waddr = next_rear;
              end else begin
                front_nxt = prev_front;
                mem_waddr = prev_front;
              end
            end
          end else if (empty) begin
            load_done   = 1'b1;
            done_status = ST_UNDERFLOW;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = (in_ch.operation == OP_POP_FRONT) ? front_r : rear_r;
            count_nxt = count_r - 1'b1;
            state_nxt = S_READ;
            if (count_r == CW'(1)) begin
              front_nxt = '0;
              rear_nxt  = '0;
            end else if (in_ch.operation == OP_POP_FRONT) begin
              front_nxt = next_front;
            end else begin
              rear_nxt = prev_rear;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
      case (state_r)
        S_IDLE: begin
          if (load_done) begin
            out_valid_r <= 1'b1;
            popped_r    <= '0;
            status_r    <= done_status;
            occ_r       <= OCC_W'(count_nxt);
          end else if (out_valid_r && out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          popped_r    <= mem_rdata;
          status_r    <= ST_DONE;
          occ_r       <= OCC_W'(count_r);
        end
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0) && (rear_r == '0))
    else $error("empty queue with pointers off zero");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("pop read completes onto an occupied result register");

  a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_push && !empty) |=> (state_r == S_READ) && !in_ch.ready)
    else $error("pop did not enter read cycle");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_DONE)) |-> (popped_r == '0))
    else $error("failed operation returned a nonzero word");

endmodule

@@ rtl/circular_deque_top.sv @@
// circular_deque_top: double-ended queue of signed words in a circular store.
// Push, overflow and underflow words come in the cycle after acceptance; pops
// add the store's registered read. Pushes flow one per cycle unless results
// stall; a pop holds off requests until its read completes. Reset (rst_n,
// synchronous, active low) clears pointers, count, result valid; not the store.
// Depends on cdq_pkg, cdq_if, cdq_ram and cdq_ctrl.
module circular_deque_top #(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cdq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ tb/deque_mirror.sv @@
`timescale 1ns / 100ps
// deque_mirror: watches the request and result channels of the circular deque,
// keeps a mirror of the queue and checks every result word. Uses cdq_pkg and cdq_if.
module deque_mirror #(
  parameter int DEPTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  cdq_in_if    in_ch,
  cdq_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import cdq_pkg::*;

  typedef struct packed {
    word_t   popped_value;
    status_t status;
    occ_t    occupancy;
  } result_t;

  word_t       held [DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  bit          none_held;
  result_t     awaited [$];

  function automatic int unsigned held_count();
    if (none_held) return 0;
    return ((tail_pos + DEPTH - head_pos) % DEPTH) + 1;
  endfunction

  function automatic int unsigned step_up(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  function automatic result_t apply_op(op_t op, word_t value);
    result_t r;
    r.popped_value = '0;
    r.status       = ST_DONE;
    if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
      if (!none_held && held_count() >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        if (none_held) begin
          head_pos = 0;
          tail_pos = 0;
          held[0]  = value;
        end else if (op == OP_PUSH_REAR) begin
          tail_pos       = step_up(tail_pos);
          held[tail_pos] = value;
        end else begin
          head_pos       = step_down(head_pos);
          held[head_pos] = value;
        end
        none_held = 1'b0;
      end
    end else if (none_held) begin
      r.status = ST_UNDERFLOW;
    end else begin
      r.popped_value = (op == OP_POP_FRONT) ? held[head_pos] : held[tail_pos];
      // last element goes before any index wrap
      if (head_pos == tail_pos) begin
        none_held = 1'b1;
        head_pos  = 0;
        tail_pos  = 0;
      end else if (op == OP_POP_FRONT) begin
        head_pos = step_up(head_pos);
      end else begin
        tail_pos = step_down(tail_pos);
      end
    end
    r.occupancy = occ_t'(held_count());
    return r;
  endfunction

  function automatic void flag_bad(string what, result_t want, result_t seen);
    if (fail_count < 10)
      $display("deque mismatch (%s): expected pop %0d st %0d occ %0d, got pop %0d st %0d occ %0d",
               what, want.popped_value, want.status, want.occupancy,
               seen.popped_value, seen.status, seen.occupancy);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      none_held  = 1'b1;
      head_pos   = 0;
      tail_pos   = 0;
      awaited.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.popped_value = out_ch.popped_value;
        seen.status       = out_ch.status;
        seen.occupancy    = out_ch.occupancy;
        if (awaited.size() == 0) begin
          flag_bad("unexpected word", '0, seen);
        end else begin
          want = awaited.pop_front();
          if (seen !== want) flag_bad("field", want, seen);
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited.push_back(apply_op(in_ch.operation, in_ch.push_value));
      pending = awaited.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// tb: drives directed and random deque operations into circular_deque_top with
// random idling and one long result stall. Uses cdq_pkg, cdq_if and deque_mirror.
module tb;
  import cdq_pkg::*;

  localparam int DEPTH       = 8;
  localparam int RAND_ITEMS  = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles   = 0;
  bit   calm     = 1'b0;
  bit   hold_req = 1'b0;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque_top #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_mirror #(.DEPTH(DEPTH)) mirror (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic offer(op_t op, word_t value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.push_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh0000_0000;
      1:       return 32'shFFFF_FFFF;
      2:       return 32'sh7FFF_FFFF;
      3:       return 32'sh8000_0000;
      default: return word_t'($urandom);
    endcase
  endfunction

  // result side
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 13);
      if (hold_req && !hold_done) begin
        gap       = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int    sent;
    int    push_pct;
    op_t   op;
    word_t value;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_PUSH_REAR;
    in_ch.push_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty, last element, fill to full, overflow, drain
    offer(OP_POP_FRONT,  32'sh0000_0000);
    offer(OP_POP_REAR,   32'sh1234_5678);
    offer(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    offer(OP_POP_REAR,   32'sh0000_0000);
    offer(OP_PUSH_REAR,  32'sh8000_0000);
    offer(OP_PUSH_FRONT, 32'shFFFF_FFFF);
    offer(OP_PUSH_FRONT, 32'sh0000_0000);
    offer(OP_PUSH_REAR,  32'sh0000_0001);
    offer(OP_PUSH_REAR,  32'sh5555_5555);
    offer(OP_PUSH_FRONT, 32'shAAAA_AAAA);
    offer(OP_PUSH_REAR,  32'sh1234_5678);
    offer(OP_PUSH_FRONT, 32'shDEAD_BEEF);
    offer(OP_PUSH_REAR,  32'sh0BAD_F00D);
    offer(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    offer(OP_POP_FRONT,  32'sh0000_0000);
    offer(OP_POP_FRONT,  32'sh0000_0000);
    offer(OP_POP_REAR,   32'sh0000_0000);
    offer(OP_POP_REAR,   32'sh0000_0000);
    offer(OP_POP_FRONT,  32'sh0000_0000);
    offer(OP_POP_REAR,   32'sh0000_0000);
    offer(OP_POP_FRONT,  32'sh0000_0000);
    offer(OP_POP_REAR,   32'sh0000_0000);
    offer(OP_POP_REAR,   32'sh0000_0000);
    // single element left at the wrap index
    offer(OP_PUSH_REAR,  32'sh0000_0005);
    offer(OP_PUSH_FRONT, 32'sh0000_0006);
    offer(OP_POP_REAR,   32'sh0000_0000);
    offer(OP_POP_FRONT,  32'sh0000_0000);

    sent = 0;
    for (int seg = 0; sent < RAND_ITEMS; seg++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      calm = (seg % 5 == 4);
      if (seg == 2) begin
        hold_req = 1'b1;
        push_pct = 85;
      end
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        value = pick_value();
        offer(op, value);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
